// File: hw/rtl/mrtd_pkg.sv
// shared types, result codes and helpers for the mrt table dump parser
package mrtd_pkg;

	// result kinds
	localparam logic [1:0] KIND_PEER = 2'd0;
	localparam logic [1:0] KIND_RIB  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_TYPE    = 3'd0;
	localparam logic [2:0] ERR_SUBTYPE = 3'd1;
	localparam logic [2:0] ERR_IPV6    = 3'd2;
	localparam logic [2:0] ERR_PFXLEN  = 3'd3;
	localparam logic [2:0] ERR_PEERIDX = 3'd4;

	// record type and subtypes that are parsed
	localparam logic [15:0] MRT_TYPE_TDV2    = 16'd13;
	localparam logic [15:0] MRT_SUB_PEER_IDX = 16'd1;
	localparam logic [15:0] MRT_SUB_RIB_V4   = 16'd2;
	localparam logic [31:0] MAX_PFX_BITS     = 32'd32;

	// one result item
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] entry_index;
		logic [31:0] router_id;
		logic [31:0] peer_address;
		logic [31:0] peer_as;
		logic [31:0] route_prefix;
		logic [5:0]  route_bits;
		logic [31:0] route_sequence;
		logic [31:0] entry_time;
		logic [15:0] attribute_length;
		logic [31:0] record_time;
		logic [2:0]  error_code;
	} result_t;

	// network mask for a prefix length of 0 to 32
	function automatic logic [31:0] prefix_mask(input logic [5:0] bits);
		logic [31:0] m;
		if (bits == 6'd0) begin
			m = 32'd0;
		end else begin
			m = 32'hffff_ffff << (6'd32 - bits);
		end
		return m;
	endfunction

endpackage

// File: hw/rtl/mrtd_core.sv
// parse state machine: advances one stream byte per step and forms results
module mrtd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       data_byte,
	output logic             res_valid,
	output mrtd_pkg::result_t res
);
	import mrtd_pkg::*;

	// parse phases
	localparam logic [4:0] PH_TIME   = 5'd0;
	localparam logic [4:0] PH_TYPE   = 5'd1;
	localparam logic [4:0] PH_SUB    = 5'd2;
	localparam logic [4:0] PH_LEN    = 5'd3;
	localparam logic [4:0] PH_COLL   = 5'd4;
	localparam logic [4:0] PH_VLEN   = 5'd5;
	localparam logic [4:0] PH_VIEW   = 5'd6;
	localparam logic [4:0] PH_PCOUNT = 5'd7;
	localparam logic [4:0] PH_FLAGS  = 5'd8;
	localparam logic [4:0] PH_BGPID  = 5'd9;
	localparam logic [4:0] PH_ADDR   = 5'd10;
	localparam logic [4:0] PH_AS     = 5'd11;
	localparam logic [4:0] PH_SEQ    = 5'd12;
	localparam logic [4:0] PH_BITS   = 5'd13;
	localparam logic [4:0] PH_PFX    = 5'd14;
	localparam logic [4:0] PH_RCOUNT = 5'd15;
	localparam logic [4:0] PH_RPEER  = 5'd16;
	localparam logic [4:0] PH_RTIME  = 5'd17;
	localparam logic [4:0] PH_ALEN   = 5'd18;
	localparam logic [4:0] PH_ATTR   = 5'd19;

	logic [4:0]  phase_q,    n_phase;
	logic [15:0] count_q,    n_count;
	logic [31:0] word_q,     n_word;
	logic [31:0] htime_q,    n_htime;
	logic [15:0] subtype_q,  n_subtype;
	logic [31:0] seq_q,      n_seq;
	logic [31:0] prefix_q,   n_prefix;
	logic [5:0]  pfxlen_q,   n_pfxlen;
	logic [15:0] left_q,     n_left;
	logic [15:0] peers_q,    n_peers;
	logic [1:0]  flags_q,    n_flags;
	logic [63:0] fields_q,   n_fields;
	logic [15:0] extra_q,    n_extra;
	logic        halted_q,   n_halted;

	// field length in bytes for phases that assemble a word
	function automatic logic [2:0] field_len(input logic [4:0] ph, input logic [1:0] fl);
		logic [2:0] n;
		unique case (ph)
			PH_TIME, PH_LEN, PH_COLL, PH_BGPID, PH_ADDR, PH_SEQ, PH_RTIME: n = 3'd4;
			PH_TYPE, PH_SUB, PH_VLEN, PH_PCOUNT, PH_RCOUNT, PH_RPEER, PH_ALEN: n = 3'd2;
			PH_FLAGS, PH_BITS: n = 3'd1;
			PH_AS:   n = fl[1] ? 3'd4 : 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// next state and result for one byte
	always_comb begin
		logic [4:0]  ph;
		logic [2:0]  need;
		logic [15:0] cnt_inc;
		logic [31:0] word_sh;
		logic [31:0] v;
		logic [2:0]  nbytes;
		logic [31:0] byte_pos;
		logic        rib_go;
		logic [15:0] rib_attr;
		logic        fail_go;
		logic [2:0]  fail_code;
		logic [15:0] fail_idx;
		logic [15:0] idx;

		n_phase   = phase_q;
		n_count   = count_q;
		n_word    = word_q;
		n_htime   = htime_q;
		n_subtype = subtype_q;
		n_seq     = seq_q;
		n_prefix  = prefix_q;
		n_pfxlen  = pfxlen_q;
		n_left    = left_q;
		n_peers   = peers_q;
		n_flags   = flags_q;
		n_fields  = fields_q;
		n_extra   = extra_q;
		n_halted  = halted_q;
		res       = '0;
		res_valid = 1'b0;
		ph        = phase_q;
		need      = 3'd0;
		cnt_inc   = 16'd0;
		word_sh   = 32'd0;
		v         = 32'd0;
		nbytes    = 3'd0;
		byte_pos  = 32'd0;
		rib_go    = 1'b0;
		rib_attr  = extra_q;
		fail_go   = 1'b0;
		fail_code = ERR_TYPE;
		fail_idx  = 16'd0;
		idx       = fields_q[47:32];

		if (!halted_q) begin
			unique case (phase_q)
				// skip the view name
				PH_VIEW: begin
					n_count = count_q - 16'd1;
					if (n_count == 16'd0) begin
						n_phase = PH_PCOUNT;
					end
				end
				// skip the path attributes, then close the rib entry
				PH_ATTR: begin
					n_count = count_q - 16'd1;
					if (n_count == 16'd0) begin
						rib_go = 1'b1;
					end
				end
				// gather prefix bytes msb first
				PH_PFX: begin
					nbytes = 3'((7'(pfxlen_q) + 7'd7) >> 3);
					unique case (count_q[1:0])
						2'd0: byte_pos = {data_byte, 24'd0};
						2'd1: byte_pos = {8'd0, data_byte, 16'd0};
						2'd2: byte_pos = {16'd0, data_byte, 8'd0};
						2'd3: byte_pos = {24'd0, data_byte};
						default: byte_pos = 32'd0;
					endcase
					n_prefix = prefix_q | byte_pos;
					n_count  = count_q + 16'd1;
					if (n_count >= 16'(nbytes)) begin
						n_prefix = n_prefix & prefix_mask(pfxlen_q);
						n_count  = 16'd0;
						n_phase  = PH_RCOUNT;
					end
				end
				// assemble a big-endian field
				default: begin
					ph      = phase_q;
					need    = field_len(phase_q, flags_q);
					cnt_inc = count_q + 16'd1;
					word_sh = {word_q[23:0], data_byte};
					if (need == 3'd0) begin
						ph      = PH_TIME;
						need    = 3'd4;
						cnt_inc = 16'd1;
						word_sh = {24'd0, data_byte};
					end
					n_phase = ph;
					n_word  = word_sh;
					n_count = cnt_inc;
					if (cnt_inc >= 16'(need)) begin
						v       = word_sh;
						n_word  = 32'd0;
						n_count = 16'd0;
						unique case (ph)
							PH_TIME: begin
								n_htime = v;
								n_phase = PH_TYPE;
							end
							PH_TYPE: begin
								n_extra = v[15:0];
								n_phase = PH_SUB;
							end
							PH_SUB: begin
								n_subtype = v[15:0];
								n_phase   = PH_LEN;
							end
							// header complete: check type and subtype
							PH_LEN: begin
								if (extra_q != MRT_TYPE_TDV2) begin
									fail_go   = 1'b1;
									fail_code = ERR_TYPE;
								end else if (subtype_q == MRT_SUB_PEER_IDX) begin
									n_phase = PH_COLL;
								end else if (subtype_q == MRT_SUB_RIB_V4) begin
									n_phase = PH_SEQ;
								end else begin
									fail_go   = 1'b1;
									fail_code = ERR_SUBTYPE;
								end
							end
							PH_COLL: begin
								n_phase = PH_VLEN;
							end
							PH_VLEN: begin
								if (v == 32'd0) begin
									n_phase = PH_PCOUNT;
								end else begin
									n_count = v[15:0];
									n_phase = PH_VIEW;
								end
							end
							PH_PCOUNT: begin
								n_peers = v[15:0];
								n_left  = v[15:0];
								n_phase = (v[15:0] != 16'd0) ? PH_FLAGS : PH_TIME;
							end
							PH_FLAGS: begin
								n_flags = v[1:0];
								n_phase = PH_BGPID;
							end
							PH_BGPID: begin
								n_fields = {v, 32'd0};
								if (flags_q[0]) begin
									fail_go   = 1'b1;
									fail_code = ERR_IPV6;
								end else begin
									n_phase = PH_ADDR;
								end
							end
							PH_ADDR: begin
								n_fields = fields_q | {32'd0, v};
								n_phase  = PH_AS;
							end
							// peer entry complete
							PH_AS: begin
								res_valid         = 1'b1;
								res.result_kind   = KIND_PEER;
								res.entry_index   = peers_q - left_q;
								res.router_id     = fields_q[63:32];
								res.peer_address  = fields_q[31:0];
								res.peer_as       = v;
								res.record_time   = htime_q;
								n_left            = left_q - 16'd1;
								n_phase = (n_left != 16'd0) ? PH_FLAGS : PH_TIME;
							end
							PH_SEQ: begin
								n_seq   = v;
								n_phase = PH_BITS;
							end
							PH_BITS: begin
								if (v > MAX_PFX_BITS) begin
									fail_go   = 1'b1;
									fail_code = ERR_PFXLEN;
								end else begin
									n_pfxlen = v[5:0];
									n_prefix = 32'd0;
									n_phase  = (v == 32'd0) ? PH_RCOUNT : PH_PFX;
								end
							end
							PH_RCOUNT: begin
								n_left  = v[15:0];
								n_phase = (v[15:0] != 16'd0) ? PH_RPEER : PH_TIME;
							end
							PH_RPEER: begin
								n_fields = {16'd0, v[15:0], 32'd0};
								n_phase  = PH_RTIME;
							end
							PH_RTIME: begin
								n_fields = fields_q | {32'd0, v};
								n_phase  = PH_ALEN;
							end
							PH_ALEN: begin
								n_extra = v[15:0];
								if (v[15:0] == 16'd0) begin
									rib_go   = 1'b1;
									rib_attr = 16'd0;
								end else begin
									n_count = v[15:0];
									n_phase = PH_ATTR;
								end
							end
							default: begin
								n_phase = PH_TIME;
							end
						endcase
					end
				end
			endcase

			// rib entry complete: check the peer index
			if (rib_go) begin
				idx = fields_q[47:32];
				if (idx >= peers_q) begin
					fail_go   = 1'b1;
					fail_code = ERR_PEERIDX;
					fail_idx  = idx;
				end else begin
					res_valid            = 1'b1;
					res.result_kind      = KIND_RIB;
					res.entry_index      = idx;
					res.route_prefix     = prefix_q;
					res.route_bits       = pfxlen_q;
					res.route_sequence   = seq_q;
					res.entry_time       = fields_q[31:0];
					res.attribute_length = rib_attr;
					res.record_time      = htime_q;
					n_left               = left_q - 16'd1;
					n_phase = (n_left != 16'd0) ? PH_RPEER : PH_TIME;
				end
			end

			// errors latch until reset
			if (fail_go) begin
				n_halted        = 1'b1;
				res             = '0;
				res_valid       = 1'b1;
				res.result_kind = KIND_ERR;
				res.entry_index = fail_idx;
				res.record_time = htime_q;
				res.error_code  = fail_code;
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TIME;
			count_q   <= '0;
			word_q    <= '0;
			htime_q   <= '0;
			subtype_q <= '0;
			seq_q     <= '0;
			prefix_q  <= '0;
			pfxlen_q  <= '0;
			left_q    <= '0;
			peers_q   <= '0;
			flags_q   <= '0;
			fields_q  <= '0;
			extra_q   <= '0;
			halted_q  <= 1'b0;
		end else if (step_en) begin
			phase_q   <= n_phase;
			count_q   <= n_count;
			word_q    <= n_word;
			htime_q   <= n_htime;
			subtype_q <= n_subtype;
			seq_q     <= n_seq;
			prefix_q  <= n_prefix;
			pfxlen_q  <= n_pfxlen;
			left_q    <= n_left;
			peers_q   <= n_peers;
			flags_q   <= n_flags;
			fields_q  <= n_fields;
			extra_q   <= n_extra;
			halted_q  <= n_halted;
		end
	end

endmodule

// File: hw/rtl/mrt_table_dump_parser.sv
// top level of the mrt table dump v2 byte stream parser
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   input    | in_valid / in_stall   | data_byte
//   output   | out_valid / out_stall | result_kind .. error_code (12 fields)
//
// one byte per cycle sustained while the output is not stalled: a transferred byte waits
// in the input register and is parsed out of it; its result, if any, moves into the output
// register when the pipeline advances, and is transferred from there.
// reset clears the parse state to the start of a record header and empties
// both registers. a stalled output holds its result and freezes the input
// register, so in_stall follows out_stall while a result is waiting.
module mrt_table_dump_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] entry_index,
	output logic [31:0] router_id,
	output logic [31:0] peer_address,
	output logic [31:0] peer_as,
	output logic [31:0] route_prefix,
	output logic [5:0]  route_bits,
	output logic [31:0] route_sequence,
	output logic [31:0] entry_time,
	output logic [15:0] attribute_length,
	output logic [31:0] record_time,
	output logic [2:0]  error_code
);
	import mrtd_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       core_valid;
	result_t    core_res;
	logic       out_valid_q;
	result_t    result_q;

	// pipeline moves whenever the output register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			data_byte_s1 <= data_byte;
		end
	end

	// parse state machine
	mrtd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance && valid_s1),
		.data_byte (data_byte_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && core_valid) begin
			result_q <= core_res;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = result_q.result_kind;
	assign entry_index      = result_q.entry_index;
	assign router_id        = result_q.router_id;
	assign peer_address     = result_q.peer_address;
	assign peer_as          = result_q.peer_as;
	assign route_prefix     = result_q.route_prefix;
	assign route_bits       = result_q.route_bits;
	assign route_sequence   = result_q.route_sequence;
	assign entry_time       = result_q.entry_time;
	assign attribute_length = result_q.attribute_length;
	assign record_time      = result_q.record_time;
	assign error_code       = result_q.error_code;

endmodule

// File: verif/mrtd_result_checker.sv
// checker for the mrt table dump parser: predicts each result and compares it
module mrtd_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  result_kind,
	input  logic [15:0] entry_index,
	input  logic [31:0] router_id,
	input  logic [31:0] peer_address,
	input  logic [31:0] peer_as,
	input  logic [31:0] route_prefix,
	input  logic [5:0]  route_bits,
	input  logic [31:0] route_sequence,
	input  logic [31:0] entry_time,
	input  logic [15:0] attribute_length,
	input  logic [31:0] record_time,
	input  logic [2:0]  error_code,
	output int          fail_count,
	output int          pending
);
	import mrtd_pkg::*;

	// where the parser stands within a record
	typedef enum logic [4:0] {
		ST_STAMP, ST_TYPE, ST_SUBTYPE, ST_LENGTH, ST_COLLECTOR, ST_VIEW_LEN, ST_VIEW_SKIP,
		ST_PEER_COUNT, ST_FLAGS, ST_BGP_ID, ST_ADDRESS, ST_ASN, ST_SEQUENCE, ST_PFX_BITS,
		ST_PFX_BYTES, ST_ROUTE_COUNT, ST_PEER_INDEX, ST_ORIG_TIME, ST_ATTR_LEN, ST_ATTR_SKIP
	} phase_e;

	phase_e      phase;
	logic [15:0] byte_count;
	logic [31:0] shift_word;
	logic [31:0] hdr_time;
	logic [15:0] hdr_type;
	logic [15:0] hdr_subtype;
	logic [31:0] seq_hold;
	logic [31:0] pfx_hold;
	logic [5:0]  pfx_bits;
	logic [15:0] entries_left;
	logic [15:0] peer_total;
	logic [1:0]  flags_hold;
	logic [31:0] id_hold;
	logic [31:0] addr_hold;
	logic [15:0] idx_hold;
	logic [31:0] orig_hold;
	logic [15:0] alen_hold;
	bit          halted;

	result_t results_due[$];

	// print one line and count it
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// error result, parsing stops until reset
	function automatic bit raise_error(input logic [2:0] code, input logic [15:0] index,
			output result_t r);
		r = '0;
		halted = 1'b1;
		r.result_kind = KIND_ERR;
		r.entry_index = index;
		r.record_time = hdr_time;
		r.error_code = code;
		return 1'b1;
	endfunction

	// rib entry complete: check the peer index and emit the route
	function automatic bit close_route(output result_t r);
		r = '0;
		if (idx_hold >= peer_total) begin
			return raise_error(ERR_PEERIDX, idx_hold, r);
		end
		r.result_kind = KIND_RIB;
		r.entry_index = idx_hold;
		r.route_prefix = pfx_hold;
		r.route_bits = pfx_bits;
		r.route_sequence = seq_hold;
		r.entry_time = orig_hold;
		r.attribute_length = alen_hold;
		r.record_time = hdr_time;
		entries_left = entries_left - 16'd1;
		phase = (entries_left != 16'd0) ? ST_PEER_INDEX : ST_STAMP;
		return 1'b1;
	endfunction

	// advance the parser by one byte, returns 1 when a result is due
	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		logic [31:0] v;
		int need;
		int nbytes;
		r = '0;
		if (halted) begin
			return 1'b0;
		end

		// skipped and prefix bytes bypass the field assembly
		if (phase == ST_VIEW_SKIP) begin
			byte_count = byte_count - 16'd1;
			if (byte_count == 16'd0) begin
				phase = ST_PEER_COUNT;
			end
			return 1'b0;
		end
		if (phase == ST_ATTR_SKIP) begin
			byte_count = byte_count - 16'd1;
			if (byte_count == 16'd0) begin
				return close_route(r);
			end
			return 1'b0;
		end
		if (phase == ST_PFX_BYTES) begin
			nbytes = (int'(pfx_bits) + 7) / 8;
			pfx_hold = pfx_hold | (32'(b) << (24 - 8 * int'(byte_count[1:0])));
			byte_count = byte_count + 16'd1;
			if (int'(byte_count) >= nbytes) begin
				pfx_hold = pfx_hold & ~(32'hffff_ffff >> pfx_bits);
				byte_count = 16'd0;
				phase = ST_ROUTE_COUNT;
			end
			return 1'b0;
		end

		// big-endian field assembly
		case (phase)
			ST_TYPE, ST_SUBTYPE, ST_VIEW_LEN, ST_PEER_COUNT, ST_ROUTE_COUNT, ST_PEER_INDEX,
			ST_ATTR_LEN: need = 2;
			ST_FLAGS, ST_PFX_BITS: need = 1;
			ST_ASN: need = flags_hold[1] ? 4 : 2;
			default: need = 4;
		endcase
		shift_word = {shift_word[23:0], b};
		byte_count = byte_count + 16'd1;
		if (int'(byte_count) < need) begin
			return 1'b0;
		end
		v = shift_word;
		shift_word = '0;
		byte_count = 16'd0;

		// act on the completed field
		case (phase)
			ST_STAMP: begin
				hdr_time = v;
				phase = ST_TYPE;
			end
			ST_TYPE: begin
				hdr_type = v[15:0];
				phase = ST_SUBTYPE;
			end
			ST_SUBTYPE: begin
				hdr_subtype = v[15:0];
				phase = ST_LENGTH;
			end
			ST_LENGTH: begin
				if (hdr_type != MRT_TYPE_TDV2) begin
					return raise_error(ERR_TYPE, 16'd0, r);
				end
				if (hdr_subtype == MRT_SUB_PEER_IDX) begin
					phase = ST_COLLECTOR;
				end else if (hdr_subtype == MRT_SUB_RIB_V4) begin
					phase = ST_SEQUENCE;
				end else begin
					return raise_error(ERR_SUBTYPE, 16'd0, r);
				end
			end
			ST_COLLECTOR: phase = ST_VIEW_LEN;
			ST_VIEW_LEN: begin
				if (v == 32'd0) begin
					phase = ST_PEER_COUNT;
				end else begin
					byte_count = v[15:0];
					phase = ST_VIEW_SKIP;
				end
			end
			ST_PEER_COUNT: begin
				peer_total = v[15:0];
				entries_left = v[15:0];
				phase = (entries_left != 16'd0) ? ST_FLAGS : ST_STAMP;
			end
			ST_FLAGS: begin
				flags_hold = v[1:0];
				phase = ST_BGP_ID;
			end
			ST_BGP_ID: begin
				id_hold = v;
				if (flags_hold[0]) begin
					return raise_error(ERR_IPV6, 16'd0, r);
				end
				phase = ST_ADDRESS;
			end
			ST_ADDRESS: begin
				addr_hold = v;
				phase = ST_ASN;
			end
			ST_ASN: begin
				r.result_kind = KIND_PEER;
				r.entry_index = peer_total - entries_left;
				r.router_id = id_hold;
				r.peer_address = addr_hold;
				r.peer_as = v;
				r.record_time = hdr_time;
				entries_left = entries_left - 16'd1;
				phase = (entries_left != 16'd0) ? ST_FLAGS : ST_STAMP;
				return 1'b1;
			end
			ST_SEQUENCE: begin
				seq_hold = v;
				phase = ST_PFX_BITS;
			end
			ST_PFX_BITS: begin
				if (v > MAX_PFX_BITS) begin
					return raise_error(ERR_PFXLEN, 16'd0, r);
				end
				pfx_bits = v[5:0];
				pfx_hold = '0;
				phase = (v == 32'd0) ? ST_ROUTE_COUNT : ST_PFX_BYTES;
			end
			ST_ROUTE_COUNT: begin
				entries_left = v[15:0];
				phase = (entries_left != 16'd0) ? ST_PEER_INDEX : ST_STAMP;
			end
			ST_PEER_INDEX: begin
				idx_hold = v[15:0];
				phase = ST_ORIG_TIME;
			end
			ST_ORIG_TIME: begin
				orig_hold = v;
				phase = ST_ATTR_LEN;
			end
			ST_ATTR_LEN: begin
				alen_hold = v[15:0];
				if (alen_hold == 16'd0) begin
					return close_route(r);
				end
				byte_count = v[15:0];
				phase = ST_ATTR_SKIP;
			end
			default: phase = ST_STAMP;
		endcase
		return 1'b0;
	endfunction

	// watch both channels: compare each result transfer, predict each byte transfer
	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			phase = ST_STAMP;
			byte_count = '0;
			shift_word = '0;
			hdr_time = '0;
			hdr_type = '0;
			hdr_subtype = '0;
			seq_hold = '0;
			pfx_hold = '0;
			pfx_bits = '0;
			entries_left = '0;
			peer_total = '0;
			flags_hold = '0;
			id_hold = '0;
			addr_hold = '0;
			idx_hold = '0;
			orig_hold = '0;
			alen_hold = '0;
			halted = 1'b0;
			results_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {result_kind, entry_index, router_id, peer_address, peer_as,
					route_prefix, route_bits, route_sequence, entry_time, attribute_length,
					record_time, error_code};
				if (results_due.size() == 0) begin
					report_mismatch("result with nothing expected, kind",
						32'(seen.result_kind), '0);
				end else begin
					want = results_due.pop_front();
					if (seen.result_kind !== want.result_kind)
						report_mismatch("result_kind", 32'(seen.result_kind),
							32'(want.result_kind));
					if (seen.entry_index !== want.entry_index)
						report_mismatch("entry_index", 32'(seen.entry_index),
							32'(want.entry_index));
					if (seen.router_id !== want.router_id)
						report_mismatch("router_id", seen.router_id, want.router_id);
					if (seen.peer_address !== want.peer_address)
						report_mismatch("peer_address", seen.peer_address, want.peer_address);
					if (seen.peer_as !== want.peer_as)
						report_mismatch("peer_as", seen.peer_as, want.peer_as);
					if (seen.route_prefix !== want.route_prefix)
						report_mismatch("route_prefix", seen.route_prefix, want.route_prefix);
					if (seen.route_bits !== want.route_bits)
						report_mismatch("route_bits", 32'(seen.route_bits),
							32'(want.route_bits));
					if (seen.route_sequence !== want.route_sequence)
						report_mismatch("route_sequence", seen.route_sequence,
							want.route_sequence);
					if (seen.entry_time !== want.entry_time)
						report_mismatch("entry_time", seen.entry_time, want.entry_time);
					if (seen.attribute_length !== want.attribute_length)
						report_mismatch("attribute_length", 32'(seen.attribute_length),
							32'(want.attribute_length));
					if (seen.record_time !== want.record_time)
						report_mismatch("record_time", seen.record_time, want.record_time);
					if (seen.error_code !== want.error_code)
						report_mismatch("error_code", 32'(seen.error_code),
							32'(want.error_code));
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_byte(data_byte, fresh)) begin
					results_due.push_back(fresh);
				end
			end
			pending = results_due.size();
		end
	end

endmodule

// File: verif/tb_mrt_table_dump_parser.sv
// testbench top for the mrt table dump parser: byte stream stimulus and verdict
module tb_mrt_table_dump_parser;
	import mrtd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [15:0] entry_index;
	logic [31:0] router_id;
	logic [31:0] peer_address;
	logic [31:0] peer_as;
	logic [31:0] route_prefix;
	logic [5:0]  route_bits;
	logic [31:0] route_sequence;
	logic [31:0] entry_time;
	logic [15:0] attribute_length;
	logic [31:0] record_time;
	logic [2:0]  error_code;
	int          fail_count;
	int          pending;

	logic [7:0] byte_stream[$];
	int         peers_known;

	mrt_table_dump_parser dut (.*);

	mrtd_result_checker checker_i (.*);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	// big-endian field of n bytes
	function automatic void put_word(input logic [31:0] value, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			byte_stream.push_back(value[8 * i +: 8]);
		end
	endfunction

	// common header, the length field is never looked at
	function automatic void put_header(input logic [31:0] stamp, input logic [15:0] kind,
			input logic [15:0] sub);
		put_word(stamp, 4);
		put_word(32'(kind), 2);
		put_word(32'(sub), 2);
		put_word($urandom, 4);
	endfunction

	// peer index table up to the first peer entry
	function automatic void put_peer_table(input logic [31:0] stamp, input int view_len,
			input int count);
		put_header(stamp, MRT_TYPE_TDV2, MRT_SUB_PEER_IDX);
		put_word($urandom, 4);
		put_word(view_len, 2);
		repeat (view_len) byte_stream.push_back(8'($urandom_range(0, 255)));
		put_word(count, 2);
		peers_known = count;
	endfunction

	function automatic void put_peer(input logic [7:0] flags, input logic [31:0] id,
			input logic [31:0] addr, input logic [31:0] asn);
		byte_stream.push_back(flags);
		put_word(id, 4);
		put_word(addr, 4);
		put_word(asn, flags[1] ? 4 : 2);
	endfunction

	// ipv4 rib record up to the first route entry
	function automatic void put_rib(input logic [31:0] stamp, input logic [31:0] seq,
			input int bits, input logic [31:0] prefix, input int count);
		put_header(stamp, MRT_TYPE_TDV2, MRT_SUB_RIB_V4);
		put_word(seq, 4);
		put_word(bits, 1);
		for (int i = 0; i < (bits + 7) / 8; i++) begin
			byte_stream.push_back(prefix[31 - 8 * i -: 8]);
		end
		put_word(count, 2);
	endfunction

	function automatic void put_route(input int index, input logic [31:0] orig, input int alen);
		put_word(index, 2);
		put_word(orig, 4);
		put_word(alen, 2);
		repeat (alen) byte_stream.push_back(8'($urandom_range(0, 255)));
	endfunction

	// receiver: stall patterns in segments, one long hold-off to back the block up
	initial begin
		int seg;
		int len;
		int style;
		int k;
		out_stall = 1'b0;
		seg = 0;
		@(posedge arst_n);
		forever begin
			if (seg == 3) begin
				out_stall = 1'b1;
				for (k = 0; k < 400; k++) @(negedge clk);
			end
			style = $urandom_range(0, 3);
			len = $urandom_range(16, 96);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				case (style)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = k[0];
				endcase
			end
			seg++;
		end
	end

	// stimulus and verdict
	initial begin
		int pos;
		int run;
		int gap;
		int n;
		int bits;
		int pick;
		logic [15:0] odd_value;
		logic [7:0] flags;
		in_valid = 1'b0;
		data_byte = '0;
		arst_n = 1'b0;
		peers_known = 0;

		// directed: rib before any peer table with no entries and zero prefix length
		put_rib(32'd0, 32'd0, 0, 32'd0, 0);
		// empty peer table, then one with a skipped view name and extreme peers
		put_peer_table(32'hffff_ffff, 0, 0);
		put_peer_table($urandom, 3, 3);
		put_peer(8'h00, 32'hffff_ffff, 32'h0000_0000, 32'h0000_ffff);
		put_peer(8'hfe, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
		put_peer(8'h02, $urandom, $urandom, 32'd0);
		// full length prefix, highest valid peer index, attribute bytes
		put_rib($urandom, 32'hffff_ffff, 32, 32'hffff_ffff, 2);
		put_route(2, 32'hffff_ffff, 0);
		put_route(0, 32'd0, 3);
		// one bit and nine bit prefixes
		put_rib($urandom, $urandom, 1, 32'hffff_ffff, 1);
		put_route(1, $urandom, 1);
		put_rib($urandom, $urandom, 9, $urandom, 1);
		put_route(0, $urandom, 0);

		// random well-formed records
		while (byte_stream.size() < 1600) begin
			if (peers_known == 0 || $urandom_range(0, 3) == 0) begin
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				case ($urandom_range(0, 5))
					0, 1: put_peer_table($urandom, 0, n);
					2: put_peer_table($urandom, $urandom_range(256, 270), n);
					default: put_peer_table($urandom, $urandom_range(1, 8), n);
				endcase
				repeat (n) begin
					flags = 8'($urandom_range(0, 255)) & 8'hfe;
					put_peer(flags, $urandom, $urandom, $urandom);
				end
			end else begin
				case ($urandom_range(0, 9))
					0: bits = 0;
					1: bits = 32;
					default: bits = $urandom_range(1, 31);
				endcase
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
				put_rib($urandom, $urandom, bits, $urandom, n);
				repeat (n) begin
					case ($urandom_range(0, 19))
						0: gap = $urandom_range(200, 300);
						1, 2, 3, 4, 5, 6: gap = 0;
						default: gap = $urandom_range(1, 6);
					endcase
					put_route($urandom_range(0, peers_known - 1), $urandom, gap);
				end
			end
		end

		// one failing record ends the useful stream, then noise that must be ignored
		pick = $urandom_range(0, 4);
		case (3'(pick))
			ERR_TYPE: begin
				do odd_value = 16'($urandom_range(0, 65535));
				while (odd_value == MRT_TYPE_TDV2);
				put_header($urandom, odd_value, MRT_SUB_RIB_V4);
			end
			ERR_SUBTYPE: begin
				do odd_value = 16'($urandom_range(0, 65535));
				while (odd_value == MRT_SUB_PEER_IDX || odd_value == MRT_SUB_RIB_V4);
				put_header($urandom, MRT_TYPE_TDV2, odd_value);
			end
			ERR_IPV6: begin
				put_peer_table($urandom, 0, 1);
				byte_stream.push_back(8'($urandom_range(0, 255) | 1));
				put_word($urandom, 4);
			end
			ERR_PFXLEN: begin
				put_header($urandom, MRT_TYPE_TDV2, MRT_SUB_RIB_V4);
				put_word($urandom, 4);
				put_word($urandom_range(33, 255), 1);
			end
			default: begin
				put_rib($urandom, $urandom, $urandom_range(0, 32), $urandom, 1);
				put_route($urandom_range(peers_known, 65535), $urandom, $urandom_range(0, 4));
			end
		endcase
		repeat (40) byte_stream.push_back(8'($urandom_range(0, 255)));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender: bursts of transfers with random gaps
		pos = 0;
		while (pos < byte_stream.size()) begin
			run = $urandom_range(1, 40);
			while (run > 0 && pos < byte_stream.size()) begin
				in_valid = 1'b1;
				data_byte = byte_stream[pos];
				do @(posedge clk); while (in_stall);
				@(negedge clk);
				pos++;
				run--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				data_byte = 8'($urandom_range(0, 255));
				repeat (gap) @(negedge clk);
			end
		end
		in_valid = 1'b0;

		// drain, then give any stray result time to show up
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
